// ----- rtl/sscov_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscov_pkg
// Shared widths, defaults and the sideband type of the stroke coverage block.
// ----------------------------------------------------------------------------
package sscov_pkg;

  localparam int COORD_W    = 22;             // Q13.8 input coordinate
  localparam int DIFF_W     = COORD_W + 1;    // coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;     // product of two differences
  localparam int LEN_W      = 46;             // squared length / squared distance
  localparam int DOT_W      = 47;             // signed dot and cross products
  localparam int ACR_W      = 46;             // magnitude of the cross product
  localparam int SQRT_GUARD = 8;              // extra root fraction bits
  localparam int SQ_IN_W    = LEN_W + 2 * SQRT_GUARD; // root operand
  localparam int ROOT_W     = SQ_IN_W / 2;    // root width, one bit per cell
  localparam int REM_W      = ROOT_W + 2;     // root remainder
  localparam int DIVD_W     = ACR_W + SQRT_GUARD + 1; // dividend / remainder
  localparam int QUO_W      = 24;             // distance quotient, one bit per cell
  localparam int RAD_W      = 18;             // stroke radius register
  localparam int LIM_W      = 16;             // degenerate length limit register
  localparam int DIST_W     = 33;             // signed width of the ramp math

  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int COVERAGE_BITS_DEF   = 8;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(256);
  localparam logic [LIM_W-1:0] LIMIT_RST  = LIM_W'(1);

  // configuration register indexes
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  // item control and data that rides along the cell chains
  typedef struct packed {
    logic             valid;
    logic             degen;
    logic             beyond;
    logic [ACR_W-1:0] acr;
  } sscov_side_t;

endpackage

// ----- rtl/sscov_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscov_front
// Differences, products and sums; classifies the item and picks the root
// operand for the cell chain.
// ----------------------------------------------------------------------------
module sscov_front import sscov_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_acc,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] ax,
  input  logic signed [COORD_W-1:0] ay,
  input  logic signed [COORD_W-1:0] bx,
  input  logic signed [COORD_W-1:0] by,
  input  logic [LIM_W-1:0]          limit,
  output sscov_side_t               side_o,
  output logic [SQ_IN_W-1:0]        arg_o
);

  logic v0_r, v1_r, v2_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, qx_r, qy_r;
  logic signed [PROD_W-1:0] dxx_r, dyy_r, qxx_r, qyy_r, qdx_r, qdy_r, cxy_r, cyx_r;
  logic [LEN_W-1:0]         len_r, q2_r;
  logic signed [DOT_W-1:0]  dot_r, crs_r;
  logic                     degen_nxt, beyond_nxt;
  logic [ACR_W-1:0]         acr_nxt;
  logic signed [DOT_W-1:0]  crs_neg;
  sscov_side_t              side_r;
  logic [SQ_IN_W-1:0]       arg_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_acc;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // differences, products, sums
  always_ff @(posedge clk) begin
    dx_r  <= DIFF_W'(bx) - DIFF_W'(ax);
    dy_r  <= DIFF_W'(by) - DIFF_W'(ay);
    qx_r  <= DIFF_W'(px) - DIFF_W'(ax);
    qy_r  <= DIFF_W'(py) - DIFF_W'(ay);
    dxx_r <= dx_r * dx_r;
    dyy_r <= dy_r * dy_r;
    qxx_r <= qx_r * qx_r;
    qyy_r <= qy_r * qy_r;
    qdx_r <= qx_r * dx_r;
    qdy_r <= qy_r * dy_r;
    cxy_r <= qx_r * dy_r;
    cyx_r <= qy_r * dx_r;
    len_r <= LEN_W'($unsigned(dxx_r)) + LEN_W'($unsigned(dyy_r));
    q2_r  <= LEN_W'($unsigned(qxx_r)) + LEN_W'($unsigned(qyy_r));
    dot_r <= DOT_W'(qdx_r) + DOT_W'(qdy_r);
    crs_r <= DOT_W'(cxy_r) - DOT_W'(cyx_r);
  end

  // classify the item
  always_comb begin
    degen_nxt  = (len_r == '0) || (len_r < LEN_W'(limit));
    beyond_nxt = !degen_nxt &&
                 ((dot_r < 0) || (dot_r > $signed({1'b0, len_r})));
    crs_neg    = -crs_r;
    acr_nxt    = (crs_r < 0) ? ACR_W'(crs_neg) : ACR_W'(crs_r);
  end

  always_ff @(posedge clk) begin
    side_r.degen  <= degen_nxt;
    side_r.beyond <= beyond_nxt;
    side_r.acr    <= acr_nxt;
    arg_r         <= degen_nxt ? SQ_IN_W'(q2_r) : {len_r, (2 * SQRT_GUARD)'(0)};
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= v2_r;
    end
  end

  assign side_o = side_r;
  assign arg_o  = arg_r;

endmodule

// ----- rtl/sscov_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscov_sqrt_cell
// One digit of the square root: takes two operand bits, decides one root bit.
// ----------------------------------------------------------------------------
module sscov_sqrt_cell import sscov_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  sscov_side_t        side_i,
  input  logic [SQ_IN_W-1:0] x_i,
  input  logic [ROOT_W-1:0]  root_i,
  input  logic [REM_W-1:0]   rem_i,
  output sscov_side_t        side_o,
  output logic [SQ_IN_W-1:0] x_o,
  output logic [ROOT_W-1:0]  root_o,
  output logic [REM_W-1:0]   rem_o
);

  logic [REM_W-1:0]   rem_sh, trial;
  logic               take;
  sscov_side_t        side_r;
  logic [SQ_IN_W-1:0] x_r;
  logic [ROOT_W-1:0]  root_r;
  logic [REM_W-1:0]   rem_r;

  // try the next root bit
  always_comb begin
    rem_sh = {rem_i[REM_W-3:0], x_i[SQ_IN_W-1 -: 2]};
    trial  = {root_i[REM_W-3:0], 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    side_r.degen  <= side_i.degen;
    side_r.beyond <= side_i.beyond;
    side_r.acr    <= side_i.acr;
    x_r    <= {x_i[SQ_IN_W-3:0], 2'b00};
    root_r <= {root_i[ROOT_W-2:0], take};
    rem_r  <= take ? rem_sh - trial : rem_sh;
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_i.valid;
    end
  end

  assign side_o = side_r;
  assign x_o    = x_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;

endmodule

// ----- rtl/sscov_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscov_div_cell
// One restoring division step: decides one quotient bit of weight 2^SHIFT.
// ----------------------------------------------------------------------------
module sscov_div_cell import sscov_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sscov_side_t       side_i,
  input  logic [DIVD_W-1:0] rem_i,
  input  logic [QUO_W-1:0]  quo_i,
  input  logic [ROOT_W-1:0] dvs_i,
  output sscov_side_t       side_o,
  output logic [DIVD_W-1:0] rem_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [ROOT_W-1:0] dvs_o
);

  logic [DIVD_W-1:0] dsh;
  logic              take;
  sscov_side_t       side_r;
  logic [DIVD_W-1:0] rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [ROOT_W-1:0] dvs_r;

  // compare against the shifted divisor
  always_comb begin
    dsh  = DIVD_W'(dvs_i) << SHIFT;
    take = rem_i >= dsh;
  end

  always_ff @(posedge clk) begin
    side_r.degen  <= side_i.degen;
    side_r.beyond <= side_i.beyond;
    side_r.acr    <= side_i.acr;
    rem_r  <= take ? rem_i - dsh : rem_i;
    quo_r  <= {quo_i[QUO_W-2:0], take};
    dvs_r  <= dvs_i;
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r.valid <= side_i.valid;
    end
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign dvs_o  = dvs_r;

endmodule

// ----- rtl/segment_stroke_coverage_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_stroke_coverage_top
// Anti-aliased stroke coverage of a sample by a line segment.
// Pipeline from start to out_valid: 4 front stages, 31 root cells, 24 division cells,
// 1 output stage. Throughput: one item every cycle outside reset; the
// cell chains are fully pipelined and the receiver cannot stall.
// Reset clears all valids and loads radius 256 and length limit 1.
// ----------------------------------------------------------------------------
module segment_stroke_coverage_top import sscov_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int COVERAGE_BITS   = COVERAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [RAD_W-1:0]          cfg_data,
  output logic                      out_valid,
  output logic [COVERAGE_BITS:0]    out_coverage,
  output logic                      out_degenerate,
  output logic                      out_beyond_ends
);

  localparam int LATENCY = 4 + ROOT_W + QUO_W + 1;

  logic              in_acc;
  logic [RAD_W-1:0]  radius_r;
  logic [LIM_W-1:0]  limit_r;

  sscov_side_t        sq_side [ROOT_W+1];
  logic [SQ_IN_W-1:0] sq_x    [ROOT_W+1];
  logic [ROOT_W-1:0]  sq_root [ROOT_W+1];
  logic [REM_W-1:0]   sq_rem  [ROOT_W+1];

  sscov_side_t        dv_side [QUO_W+1];
  logic [DIVD_W-1:0]  dv_rem  [QUO_W+1];
  logic [QUO_W-1:0]   dv_quo  [QUO_W+1];
  logic [ROOT_W-1:0]  dv_dvs  [QUO_W+1];

  logic signed [DIST_W-1:0]          seg_dist, rad, one, mid;
  logic [DIST_W+COVERAGE_BITS-1:0]   scaled;
  logic [COVERAGE_BITS:0]            cov_nxt;
  logic                              out_valid_r, degen_r, beyond_r;
  logic [COVERAGE_BITS:0]            cov_r;

  assign busy      = ~rst_n;
  assign in_acc    = start & ~busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data;
        CFG_LIMIT:  limit_r  <= cfg_data[LIM_W-1:0];
        default:    radius_r <= radius_r;
      endcase
    end
  end

  // products, sums, classification
  sscov_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_acc (in_acc),
    .px     (in_point_x),
    .py     (in_point_y),
    .ax     (in_start_x),
    .ay     (in_start_y),
    .bx     (in_end_x),
    .by     (in_end_y),
    .limit  (limit_r),
    .side_o (sq_side[0]),
    .arg_o  (sq_x[0])
  );

  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  // square root chain
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    sscov_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (sq_side[i]),
      .x_i    (sq_x[i]),
      .root_i (sq_root[i]),
      .rem_i  (sq_rem[i]),
      .side_o (sq_side[i+1]),
      .x_o    (sq_x[i+1]),
      .root_o (sq_root[i+1]),
      .rem_o  (sq_rem[i+1])
    );
  end

  assign dv_side[0] = sq_side[ROOT_W];
  assign dv_rem[0]  = DIVD_W'({sq_side[ROOT_W].acr, SQRT_GUARD'(0)});
  assign dv_quo[0]  = '0;
  assign dv_dvs[0]  = sq_root[ROOT_W];

  // division chain, most significant quotient bit first
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    sscov_div_cell #(.SHIFT(QUO_W - 1 - j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (dv_side[j]),
      .rem_i  (dv_rem[j]),
      .quo_i  (dv_quo[j]),
      .dvs_i  (dv_dvs[j]),
      .side_o (dv_side[j+1]),
      .rem_o  (dv_rem[j+1]),
      .quo_o  (dv_quo[j+1]),
      .dvs_o  (dv_dvs[j+1])
    );
  end

  // coverage ramp; point case takes the root, segment case the quotient
  always_comb begin
    seg_dist = dv_side[QUO_W].degen ? DIST_W'(dv_dvs[QUO_W]) : DIST_W'(dv_quo[QUO_W]);
    rad      = DIST_W'(radius_r);
    one      = DIST_W'(1) << COORD_FRAC_BITS;
    mid      = rad + one - seg_dist;
    scaled   = (DIST_W + COVERAGE_BITS)'($unsigned(mid)) << COVERAGE_BITS;
    scaled   = scaled >> (COORD_FRAC_BITS + 1);
    if (dv_side[QUO_W].beyond || seg_dist >= rad + one) begin
      cov_nxt = '0;
    end else if (seg_dist + one <= rad) begin
      cov_nxt = (COVERAGE_BITS + 1)'(1) << COVERAGE_BITS;
    end else begin
      cov_nxt = scaled[COVERAGE_BITS:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    cov_r    <= cov_nxt;
    degen_r  <= dv_side[QUO_W].degen;
    beyond_r <= dv_side[QUO_W].beyond;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_side[QUO_W].valid;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coverage    = cov_r;
  assign out_degenerate  = degen_r;
  assign out_beyond_ends = beyond_r;

  // checks
  a_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(in_acc, LATENCY))
    else $error("result strobe does not follow item by pipeline latency");
  a_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_degenerate && out_beyond_ends))
    else $error("item both degenerate and beyond ends");
  a_beyond : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beyond_ends) |-> (out_coverage == '0))
    else $error("beyond ends item with nonzero coverage");
  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coverage <= ((COVERAGE_BITS + 1)'(1) << COVERAGE_BITS)))
    else $error("coverage above full");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for segment_stroke_coverage_top. Drives a directed set
// and random bursts of sample/segment items under several radius and
// length-limit settings, predicts coverage and flags with an integer model,
// and checks every strobed result in order against the expected results.
// ----------------------------------------------------------------------------
module testbench;
  import sscov_pkg::*;

  localparam int FRAC      = COORD_FRAC_BITS_DEF;
  localparam int COV_BITS  = COVERAGE_BITS_DEF;
  localparam int DRAIN     = 80;
  localparam int STALL_MAX = 5000;
  localparam int N_RANDOM  = 152;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t px, py, ax, ay, bx, by;
  } seg_item_t;

  typedef struct {
    logic [COV_BITS:0] coverage;
    logic              degenerate;
    logic              beyond;
  } cov_result_t;

  // Scoreboard: predicts coverage for accepted items, checks strobed results
  class coverage_scoreboard;
    cov_result_t       expected_q[$];
    logic [RAD_W-1:0]  radius;
    logic [LIM_W-1:0]  len_limit;
    int                errors;
    int                n_checked;
    int                n_degen;
    int                n_beyond;

    function new();
      radius    = RADIUS_RST;
      len_limit = LIMIT_RST;
    endfunction

    function void write_reg(logic idx, logic [RAD_W-1:0] data);
      if (idx == CFG_RADIUS) radius = data;
      else len_limit = data[LIM_W-1:0];
    endfunction

    // Integer square root, floor
    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Linear falloff from r-one to r+one
    function logic [COV_BITS:0] falloff(longint d);
      longint one, r;
      one = longint'(1) << FRAC;
      r   = longint'(radius);
      if (d <= r - one) return (COV_BITS+1)'(1 << COV_BITS);
      if (d >= r + one) return '0;
      return (COV_BITS+1)'(((r + one - d) * (longint'(1) << COV_BITS)) / (2 * one));
    endfunction

    function void note_item(seg_item_t it);
      longint          dx, dy, qx, qy, dot, cr;
      longint unsigned len_sq, acr, s;
      cov_result_t     res;
      dx = longint'(it.bx) - longint'(it.ax);
      dy = longint'(it.by) - longint'(it.ay);
      qx = longint'(it.px) - longint'(it.ax);
      qy = longint'(it.py) - longint'(it.ay);
      len_sq = dx * dx + dy * dy;
      res = '{coverage: '0, degenerate: 1'b0, beyond: 1'b0};
      if (len_sq == 0 || len_sq < len_limit) begin
        res.coverage   = falloff(longint'(int_sqrt(qx * qx + qy * qy)));
        res.degenerate = 1'b1;
      end else begin
        dot = qx * dx + qy * dy;
        if (dot < 0 || longint'(dot) > longint'(len_sq)) begin
          res.beyond = 1'b1;
        end else begin
          cr  = qx * dy - qy * dx;
          acr = (cr < 0) ? -cr : cr;
          s   = int_sqrt(len_sq << (2 * SQRT_GUARD));
          res.coverage = falloff(longint'((acr << SQRT_GUARD) / s));
        end
      end
      expected_q = {expected_q, res};
    endfunction

    function void check_result(cov_result_t got);
      cov_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with none expected: cov=%0d", got.coverage);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (want.degenerate) n_degen++;
      if (want.beyond) n_beyond++;
      if (got.coverage !== want.coverage || got.degenerate !== want.degenerate ||
          got.beyond !== want.beyond) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: exp cov=%0d deg=%0b bey=%0b, got cov=%0d deg=%0b bey=%0b",
                   n_checked, want.coverage, want.degenerate, want.beyond,
                   got.coverage, got.degenerate, got.beyond);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  coord_t            in_point_x, in_point_y, in_start_x, in_start_y, in_end_x, in_end_y;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [RAD_W-1:0]  cfg_data;
  logic              out_valid;
  logic [COV_BITS:0] out_coverage;
  logic              out_degenerate;
  logic              out_beyond_ends;

  coverage_scoreboard sb;
  int                 n_items;
  int                 n_cfg;
  int                 idle_cycles;

  segment_stroke_coverage_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_coverage    (out_coverage),
    .out_degenerate  (out_degenerate),
    .out_beyond_ends (out_beyond_ends)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watch all handshakes, feed the scoreboard, guard against a hang
  always @(posedge clk) begin
    if (rst_n) begin
      logic progress;
      progress = 1'b0;
      if (out_valid) begin
        sb.check_result('{coverage: out_coverage, degenerate: out_degenerate,
                          beyond: out_beyond_ends});
        progress = 1'b1;
      end
      if (start && !busy) begin
        sb.note_item('{px: in_point_x, py: in_point_y, ax: in_start_x,
                       ay: in_start_y, bx: in_end_x, by: in_end_y});
        n_items++;
        progress = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        n_cfg++;
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("timeout: no handshake for %0d cycles", STALL_MAX);
        $display("segment_stroke_coverage_top regression: fail");
        $finish;
      end
    end
  end

  // Drive one item at the falling edge and hold it until accepted
  task automatic send_item(seg_item_t it);
    int n0;
    n0 = n_items;
    start      = 1'b1;
    in_point_x = it.px;
    in_point_y = it.py;
    in_start_x = it.ax;
    in_start_y = it.ay;
    in_end_x   = it.bx;
    in_end_y   = it.by;
    do @(negedge clk); while (n_items == n0);
  endtask

  task automatic pause(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [RAD_W-1:0] data);
    int n0;
    n0 = n_cfg;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(negedge clk); while (n_cfg == n0);
    cfg_valid = 1'b0;
  endtask

  // Hold off until every expected result is back, then let the pipe drain
  task automatic drain();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic coord_t clamp_coord(longint v);
    if (v > 2097151) return coord_t'(2097151);
    if (v < -2097152) return coord_t'(-2097152);
    return coord_t'(v);
  endfunction

  function automatic seg_item_t mk(longint px, longint py, longint ax, longint ay,
                                   longint bx, longint by);
    return '{px: coord_t'(px), py: coord_t'(py), ax: coord_t'(ax),
             ay: coord_t'(ay), bx: coord_t'(bx), by: coord_t'(by)};
  endfunction

  // Random item: mostly points near a short segment, some point-like, some wild
  function automatic seg_item_t rand_item();
    int              kind;
    longint          ax, ay, dx, dy, k;
    kind = $urandom_range(0, 9);
    if (kind < 2)
      return '{px: coord_t'($urandom), py: coord_t'($urandom), ax: coord_t'($urandom),
               ay: coord_t'($urandom), bx: coord_t'($urandom), by: coord_t'($urandom)};
    ax = longint'($urandom_range(0, 4000000)) - 2000000;
    ay = longint'($urandom_range(0, 4000000)) - 2000000;
    if (kind == 2) begin
      dx = longint'($urandom_range(0, 8)) - 4;
      dy = longint'($urandom_range(0, 8)) - 4;
    end else begin
      dx = longint'($urandom_range(0, 16384)) - 8192;
      dy = longint'($urandom_range(0, 16384)) - 8192;
    end
    k = longint'($urandom_range(0, 300)) - 22;
    return '{px: clamp_coord(ax + (dx * k) / 256 + longint'($urandom_range(0, 2400)) - 1200),
             py: clamp_coord(ay + (dy * k) / 256 + longint'($urandom_range(0, 2400)) - 1200),
             ax: coord_t'(ax), ay: coord_t'(ay),
             bx: coord_t'(ax + dx), by: coord_t'(ay + dy)};
  endfunction

  // Short fixed set per setting: corners, beyond both ends, on and near the line
  task automatic send_directed();
    send_item(mk(0, 0, 0, 0, 0, 0));
    send_item(mk(2097151, 2097151, 2097151, 2097151, 2097151, 2097151));
    send_item(mk(-2097152, -2097152, -2097152, -2097152, 2097151, 2097151));
    send_item(mk(0, 0, -2097152, -2097152, 2097151, 2097151));
    send_item(mk(-2097152, 2097151, 2097151, -2097152, -2097152, 2097151));
    send_item(mk(-256, 0, 0, 0, 2560, 0));
    send_item(mk(2816, 0, 0, 0, 2560, 0));
    send_item(mk(1280, 100, 0, 0, 2560, 0));
    send_item(mk(1280, -256, 0, 0, 2560, 0));
    send_item(mk(1280, 600, 0, 0, 2560, 0));
    send_item(mk(300, 0, 0, 0, 1, 0));
    send_item(mk(0, 200, 0, 0, 0, 0));
    pause($urandom_range(0, 3));
  endtask

  initial begin
    logic [RAD_W-1:0] radius_set[7];
    logic [RAD_W-1:0] limit_set[7];
    int               burst;
    radius_set = '{18'd256, 18'd0, 18'd262143, 18'd100, 18'd700, 18'd512, 18'd3000};
    limit_set  = '{18'd1, 18'd0, 18'd65535, 18'd300, 18'h3ffff, 18'd5, 18'd2};
    sb          = new();
    n_items     = 0;
    n_cfg       = 0;
    idle_cycles = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_RADIUS;
    cfg_data    = '0;
    in_point_x  = '0;
    in_point_y  = '0;
    in_start_x  = '0;
    in_start_y  = '0;
    in_end_x    = '0;
    in_end_y    = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Reset setting first, then sweep the register settings
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) begin
        drain();
        write_cfg(CFG_RADIUS, radius_set[ph]);
        write_cfg(CFG_LIMIT, limit_set[ph]);
      end
      send_directed();
      for (int i = 0; i < N_RANDOM; ) begin
        burst = (ph == 2) ? N_RANDOM : $urandom_range(1, 24);
        for (int j = 0; j < burst && i < N_RANDOM; j++, i++) send_item(rand_item());
        pause($urandom_range(0, 6));
      end
    end
    drain();

    $display("covered %0d items over %0d register writes: %0d point-like, %0d beyond ends",
             n_items, n_cfg, sb.n_degen, sb.n_beyond);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("segment_stroke_coverage_top regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("segment_stroke_coverage_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sscov_pkg.sv
rtl/sscov_front.sv
rtl/sscov_sqrt_cell.sv
rtl/sscov_div_cell.sv
rtl/segment_stroke_coverage_top.sv
test/testbench.sv
